FILE: design/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared definitions of the URL percent decoder
// Character constants, the decoded-byte bundle that travels from the front
// end to the back end, and the hex digit helpers.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned NIB_W = 4;
   localparam int unsigned MAX_OUT = 3;
   localparam int unsigned COUNT_W = 2;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
   localparam logic [BYTE_W-1:0] PLUS_CHAR = 8'h2B;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

   // What the front end keeps between characters.
   typedef enum logic [2:0] {
      HOLD_NONE = 3'b001,
      HOLD_PCT  = 3'b010,
      HOLD_HEX  = 3'b100
   } hold_type;

   // All bytes caused by one input character, with their count (1 to 3).
   typedef struct packed {
      logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
      logic [COUNT_W-1:0]             count;
      logic                           last;
   } bundle_type;

   // A write into the queue.
   typedef struct packed {
      logic       push;
      bundle_type bundle;
   } push_type;

   // True for 0-9, a-f and A-F.
   function automatic logic is_hex(input logic [BYTE_W-1:0] c);
      logic r;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Value of a hex digit; letters of either case have 1 to 6 in the low nibble.
   function automatic logic [NIB_W-1:0] hex_nibble(input logic [BYTE_W-1:0] c);
      logic [NIB_W-1:0] r;
      case (c) inside
         [8'h41:8'h46], [8'h61:8'h66]: r = c[NIB_W-1:0] + 4'd9;
         default: r = c[NIB_W-1:0];
      endcase
      return r;
   endfunction

endpackage

FILE: design/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent decoder
// Decodes percent escapes and plus signs of a character stream, one
// character per transfer in, one decoded byte per transfer out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                      Handshake
//  req_      in         in_byte[7:0], last_in                        valid/stall
//  rsp_      out        out_byte[7:0], run_last, string_last         valid/stall
//
//  One character is taken per cycle while the queue is not full; a character
//  that yields k bytes (k is 0 to 3) occupies the output serializer for k
//  transfers, one decoded byte each, with the queue of QUEUE_DEPTH bundles
//  absorbing bursts. A request passes through the queue, then the output register.
//  Synchronous reset clears the hold state, the queue and the output register.
//  A response stall holds the output byte; the request side stalls only when
//  the queue is full.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_last_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_string_last
);

   push_type   push;
   logic       full;
   logic       head_valid;
   bundle_type head;
   logic       pop;

   assign req_stall = full;

   // Classifier.
   upd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_last_in (req_last_in),
      .push_out    (push)
   );

   // Bundle queue.
   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Serializer.
   upd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

FILE: design/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: character classifier
// Holds a pending percent sign and first hex digit, and turns each accepted
// character into a bundle of decoded bytes for the queue.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [BYTE_W-1:0]   req_in_byte,
   input  logic                req_last_in,
   output push_type            push_out
);

   hold_type            hold_ff, hold_in;
   logic [BYTE_W-1:0]   held_char_ff, held_char_in;
   logic                accept;

   bundle_type          bnd;
   logic                plain_hold;
   logic [BYTE_W-1:0]   plain_byte;

   assign accept = req_valid && !req_stall;

   // A character looked at with nothing held.
   always_comb begin
      plain_hold = (req_in_byte == PCT_CHAR);
      plain_byte = (req_in_byte == PLUS_CHAR) ? SPACE_CHAR : req_in_byte;
   end

   // Build the bundle and the next hold state.
   always_comb begin
      bnd.bytes = '0;
      bnd.count = '0;
      bnd.last = req_last_in;
      hold_in = HOLD_NONE;
      held_char_in = held_char_ff;
      case (hold_ff)
         HOLD_PCT: begin
            if (is_hex(req_in_byte)) begin
               hold_in = HOLD_HEX;
               held_char_in = req_in_byte;
            end else begin
               bnd.bytes[0] = PCT_CHAR;
               if (plain_hold) begin
                  hold_in = HOLD_PCT;
                  bnd.count = 2'd1;
               end else begin
                  bnd.bytes[1] = plain_byte;
                  bnd.count = 2'd2;
               end
            end
         end
         HOLD_HEX: begin
            if (is_hex(req_in_byte)) begin
               bnd.bytes[0] = {hex_nibble(held_char_ff), hex_nibble(req_in_byte)};
               bnd.count = 2'd1;
            end else begin
               bnd.bytes[0] = PCT_CHAR;
               bnd.bytes[1] = held_char_ff;
               if (plain_hold) begin
                  hold_in = HOLD_PCT;
                  bnd.count = 2'd2;
               end else begin
                  bnd.bytes[2] = plain_byte;
                  bnd.count = 2'd3;
               end
            end
         end
         default: begin
            if (plain_hold) begin
               hold_in = HOLD_PCT;
            end else begin
               bnd.bytes[0] = plain_byte;
               bnd.count = 2'd1;
            end
         end
      endcase

      // End of string: flush whatever is still held.
      if (req_last_in) begin
         if (hold_in == HOLD_PCT) begin
            bnd.bytes[bnd.count] = PCT_CHAR;
            bnd.count = bnd.count + 2'd1;
         end else if (hold_in == HOLD_HEX) begin
            bnd.bytes[0] = PCT_CHAR;
            bnd.bytes[1] = held_char_in;
            bnd.count = 2'd2;
         end
         hold_in = HOLD_NONE;
      end
   end

   // Only bundles that carry bytes enter the queue.
   always_comb begin
      push_out.push = accept && (bnd.count != '0);
      push_out.bundle = bnd;
   end

   // Hold state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_NONE;
      end else if (accept) begin
         hold_ff <= hold_in;
      end
   end

   // Held hex digit.
   always_ff @(posedge clock) begin
      if (accept) begin
         held_char_ff <= held_char_in;
      end
   end

endmodule

FILE: design/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue: bundle queue
// A small first-in first-out queue of bundles between front and back end.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push_in,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output bundle_type head
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   bundle_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head = entry_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_in.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.bundle;
      end
   end

endmodule

FILE: design/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: byte serializer
// Sends the bytes of the head bundle one per transfer through an output
// register, and retires the bundle after its final byte.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bundle_type        head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_string_last
);

   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic                valid_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic                run_last_ff;
   logic                string_last_ff;
   logic                load;
   logic                take;
   logic                fin;

   // The output register takes a new byte when empty or being drained.
   assign load = !valid_ff || !rsp_stall;
   assign take = load && head_valid;
   assign fin = (idx_ff == head.count - 2'd1);
   assign pop = take && fin;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = fin ? '0 : idx_ff + 2'd1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            valid_ff <= head_valid;
         end
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= head.bytes[idx_ff];
         run_last_ff <= fin;
         string_last_ff <= fin && head.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_string_last = string_last_ff;

endmodule

FILE: design/upd_checker.sv
// ----------------------------------------------------------------------------
// upd_checker: port checks of the URL percent decoder
// Watches the top level's ports and flags response sequences that the
// decoder must never show.
// ----------------------------------------------------------------------------
module upd_checker import upd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_run_last,
   input logic              rsp_string_last
);

   // A stalled response stays valid and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_string_last))
      else $error("stalled response changed");

   // The final byte of a string is always the final byte of its character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_last |-> rsp_run_last)
      else $error("string end without run end");

   // Bytes of one character leave back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("gap inside a character's bytes");

   // Nothing is shown in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   // A request presented right after reset is accepted.
   assert property (@(posedge clock)
      $past(reset) && !reset && req_valid |-> !req_stall)
      else $error("request stall out of reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_string_last (rsp_string_last)
);
